// ----- design/assert_macros.svh -----
// Assertion macros shared by the temperature rise detector RTL.
// Self-contained; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Check expr on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error(msg);

`endif

// ----- design/trd_pkg.sv -----
// Shared types and constants for the temperature rise detector.
// No dependencies.
package trd_pkg;

  localparam int SAMPLE_W = 11;
  localparam int GAS_W    = 2;
  localparam int THR_W    = 8;
  localparam int WIN_LEN  = 5;
  localparam int CNT_W    = 3;
  localparam int LVL_W    = 2;
  localparam int FILL_W   = $clog2(WIN_LEN + 1);

  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int MAG_W    = SAMPLE_W + 2;
  localparam int RECIP_W  = MAG_W + 2;
  localparam int DIFF_W   = SAMPLE_W + 1;

  localparam int IN_DATA_W  = ((SAMPLE_W + GAS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((LVL_W + CNT_W + 7) / 8) * 8;

  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((2 ** RECIP_W + 4) / 5);
  localparam logic [THR_W-1:0]   THR_RST = THR_W'(2);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(6);
  localparam logic [CNT_W-1:0]   CNT_ZERO = CNT_W'(0);
  localparam logic [CNT_W-1:0]   CNT_MID_LO = CNT_W'(3);
  localparam logic [CNT_W-1:0]   CNT_MID_HI = CNT_W'(4);
  localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(WIN_LEN);
  localparam logic [GAS_W-1:0]   GAS_NONE = GAS_W'(0);

  typedef enum logic [LVL_W-1:0] {
    LVL_NORMAL    = 2'd0,
    LVL_RISING    = 2'd1,
    LVL_SUSTAINED = 2'd2
  } level_e;

  typedef struct packed {
    logic                       adv;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] sample;
  } win_ctrl_t;

  typedef struct packed {
    logic                    full;
    logic signed [SUM_W-1:0] sum;
  } win_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    level_e           lvl;
  } hyst_t;

endpackage

// ----- design/trd_window.sv -----
// Sample window with running sum and fill count.
// Depends on trd_pkg.
module trd_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  trd_pkg::win_ctrl_t ctrl_i,
  output trd_pkg::win_stat_t stat_o
);
  import trd_pkg::*;

  logic signed [SAMPLE_W-1:0] win_q [WIN_LEN];
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic                       full;
  logic signed [SUM_W-1:0]    add_ext, sub_ext;

  assign full    = (fill_q == FILL_FULL);
  assign add_ext = SUM_W'(ctrl_i.sample);
  assign sub_ext = full ? SUM_W'(win_q[0]) : '0;

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    if (ctrl_i.adv && ctrl_i.shift) begin
      sum_d = sum_q + add_ext - sub_ext;
    end
    if (ctrl_i.adv && !full) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv && ctrl_i.shift) begin
      for (int k = 0; k < WIN_LEN - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[WIN_LEN-1] <= ctrl_i.sample;
    end
  end

  assign stat_o.full = full;
  assign stat_o.sum  = sum_q;

endmodule

// ----- design/trd_mean.sv -----
// Window mean: signed sum divided by the window length, truncated toward zero.
// Depends on trd_pkg; uses a constant reciprocal multiply.
module trd_mean (
  input  logic signed [trd_pkg::SUM_W-1:0]    sum_i,
  output logic signed [trd_pkg::SAMPLE_W-1:0] mean_o
);
  import trd_pkg::*;

  logic                       neg;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W+RECIP_W-1:0]   prod;
  logic [SAMPLE_W-1:0]        quo;

  assign neg  = sum_i[SUM_W-1];
  assign mag  = neg ? MAG_W'(-sum_i) : MAG_W'(sum_i);
  assign prod = (MAG_W + RECIP_W)'(mag) * (MAG_W + RECIP_W)'(RECIP);
  assign quo  = prod[RECIP_W +: SAMPLE_W];
  assign mean_o = neg ? $signed(-quo) : $signed(quo);

endmodule

// ----- design/trd_hyst.sv -----
// Rise hysteresis counter and temperature level register.
// Depends on trd_pkg.
module trd_hyst (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           rise_i,
  output trd_pkg::hyst_t nxt_o,
  output trd_pkg::hyst_t cur_o
);
  import trd_pkg::*;

  hyst_t st_q, st_d;
  logic  mid;

  assign mid = (st_q.cnt == CNT_MID_LO) || (st_q.cnt == CNT_MID_HI);

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      if (rise_i) begin
        if (st_q.cnt == CNT_MAX) begin
          st_d.lvl = LVL_SUSTAINED;
        end else begin
          if (mid) st_d.lvl = LVL_RISING;
          st_d.cnt = st_q.cnt + CNT_W'(1);
        end
      end else begin
        if (st_q.cnt == CNT_ZERO) begin
          st_d.lvl = LVL_NORMAL;
        end else begin
          if (mid) st_d.lvl = LVL_RISING;
          st_d.cnt = st_q.cnt - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.cnt <= CNT_ZERO;
      st_q.lvl <= LVL_NORMAL;
    end else begin
      st_q <= st_d;
    end
  end

  assign nxt_o = st_d;
  assign cur_o = st_q;

endmodule

// ----- design/temperature_rise_detector.sv -----
// Temperature rise detector top level: input register, classify, result register.
// Path: an accepted item is held in the input register, then classified into the result register.
// Throughput: one item per cycle unless m_axis_tready holds back the result register.
// Reset (rst_ni, async low): empties both stages, clears fill count, running sum,
// rise counter and level; rise_threshold returns to 2. No clearing pass.
// Depends on trd_pkg, trd_window, trd_mean, trd_hyst, assert_macros.svh.
`include "assert_macros.svh"
module temperature_rise_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [trd_pkg::THR_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [10:0] temperature, [12:11] gas_level, rest zero
  input  logic [trd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] temp_level, [4:2] rise_count, rest zero
  output logic [trd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] window_full
  output logic                           m_axis_tuser
);
  import trd_pkg::*;

  logic [THR_W-1:0]           thr_q;
  logic                       in_vld_q, in_vld_d;
  logic signed [SAMPLE_W-1:0] in_temp_q;
  logic [GAS_W-1:0]           in_gas_q;
  logic                       out_vld_q, out_vld_d;
  hyst_t                      out_st_q;
  logic                       out_full_q;
  logic                       take, adv, rise;
  win_ctrl_t                  win_ctrl;
  win_stat_t                  win_stat;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [DIFF_W-1:0]   diff, thr_ext;
  hyst_t                      hyst_nxt, hyst_cur;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (adv) out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RST;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_temp_q <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      in_gas_q  <= s_axis_tdata[SAMPLE_W +: GAS_W];
    end
    if (adv) begin
      out_st_q   <= hyst_nxt;
      out_full_q <= win_stat.full;
    end
  end

  trd_mean u_mean (
    .sum_i  (win_stat.sum),
    .mean_o (mean)
  );

  assign diff    = DIFF_W'(in_temp_q) - DIFF_W'(mean);
  assign thr_ext = $signed({{(DIFF_W - THR_W){1'b0}}, thr_q});
  assign rise    = win_stat.full && (diff >= thr_ext);

  assign win_ctrl.adv    = adv;
  assign win_ctrl.shift  = !rise || (in_gas_q == GAS_NONE);
  assign win_ctrl.sample = in_temp_q;

  trd_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .stat_o (win_stat)
  );

  trd_hyst u_hyst (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv && win_stat.full),
    .rise_i (rise),
    .nxt_o  (hyst_nxt),
    .cur_o  (hyst_cur)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - CNT_W - LVL_W){1'b0}}, out_st_q.cnt, out_st_q.lvl};
  assign m_axis_tuser  = out_full_q;

  `ASSERT_ALWAYS(a_cnt_range, clk_i, rst_ni, hyst_cur.cnt <= CNT_MAX, "rise counter out of range")
  `ASSERT_IMPLIES(a_fill_idle, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, (out_st_q.cnt == CNT_ZERO) && (out_st_q.lvl == LVL_NORMAL), "counter moved while window filling")
  `ASSERT_NEXT(a_full_sticks, clk_i, rst_ni, win_stat.full, win_stat.full, "window lost its full state")

endmodule
